// ----- src/ctwa_pkg.sv -----
package ctwa_pkg;

    // Table geometry.
    localparam int MaxClients = 16;
    localparam int IdxW       = (MaxClients > 1) ? $clog2(MaxClients) : 1;
    localparam int CntW       = $clog2(MaxClients + 1);

    // Field widths.
    localparam int HostW    = 32;
    localparam int PortW    = 16;
    localparam int TimeW    = 32;
    localparam int ElapsedW = 16;
    localparam int TimeoutW = 16;
    localparam int KindW    = 2;
    localparam int CountW   = 5;

    localparam logic [9:0]          MS_PER_SECOND   = 10'd1000;
    localparam logic [TimeoutW-1:0] TIMEOUT_RESET   = 16'd5;

    typedef enum logic [KindW-1:0] {
        KIND_CONNECT    = 2'd0,
        KIND_ALIVE      = 2'd1,
        KIND_DISCONNECT = 2'd2,
        KIND_DATA       = 2'd3
    } pkt_kind_t;

    typedef enum logic {
        ACK_CONNECT = 1'b0,
        ACK_ALIVE   = 1'b1
    } ack_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_WRITE
    } ctwa_state_t;

endpackage

// ----- src/connection_table_with_aging.sv -----
// Channel      | Handshake          | Payload
// -------------+--------------------+------------------------------------------------
// input  (s_)  | s_valid / s_ready  | elapsed_ms, packet_valid, source_host/port, kind
// result (m_)  | m_valid / m_ready  | is_member, reply_*, client_count, table_full
// config       | cfg_we (no wait)   | cfg_wdata -> timeout_seconds
//
// For each transaction, the accepting cycle latches the item and advances the clock,
// the sweep then runs aging and lookup over each of the 16 table entries in turn
// through the shared age compare, and a write-back follows. The result register loads
// at write-back, and the next transaction can be taken in the cycle after write-back.
// The write-back cycle waits while the previous result is still held on the result
// channel. Reset (aresetn, synchronous, active low) clears the clock, the valid bits
// and the timeout register to 5 seconds.

module connection_table_with_aging (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_we,
    input  logic [ctwa_pkg::TimeoutW-1:0] cfg_wdata,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ctwa_pkg::ElapsedW-1:0] s_elapsed_ms,
    input  logic                          s_packet_valid,
    input  logic [ctwa_pkg::HostW-1:0]    s_source_host,
    input  logic [ctwa_pkg::PortW-1:0]    s_source_port,
    input  logic [ctwa_pkg::KindW-1:0]    s_packet_kind,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_is_member,
    output logic                          m_reply_valid,
    output logic                          m_reply_kind,
    output logic [ctwa_pkg::HostW-1:0]    m_reply_host,
    output logic [ctwa_pkg::PortW-1:0]    m_reply_port,
    output logic [ctwa_pkg::CountW-1:0]   m_client_count,
    output logic                          m_table_full
);

    import ctwa_pkg::*;

    // Sequencer state.
    ctwa_state_t state_reg, state_next;

    // Control decoded from the state.
    logic accept;
    logic sweep_en;
    logic out_free;
    logic commit;

    // Configuration and the millisecond clock, advanced by each accepted item's elapsed time.
    logic [TimeoutW-1:0] timeout_reg;
    logic [TimeW-1:0]    now_reg;
    logic [TimeW-1:0]    limit_reg;

    // Latched packet.
    logic               pkt_valid_reg;
    logic [HostW-1:0]   pkt_host_reg;
    logic [PortW-1:0]   pkt_port_reg;
    pkt_kind_t          pkt_kind_reg;

    // Sweep bookkeeping.
    logic [IdxW-1:0]       idx_reg;
    logic                  found_reg;
    logic [IdxW-1:0]       slot_reg;
    logic                  free_found_reg;
    logic [IdxW-1:0]       free_slot_reg;
    logic [CntW-1:0]       cnt_reg;

    // Entry storage: valid bits in flops, the rest in memories. The client port is
    // never read back, since every reply goes to the packet's own port, so it is
    // not stored.
    logic [MaxClients-1:0] valid_reg, valid_next;
    logic [HostW-1:0]      host_mem  [MaxClients];
    logic [TimeW-1:0]      stamp_mem [MaxClients];
    logic [HostW-1:0]      host_rd;
    logic [TimeW-1:0]      stamp_rd;
    logic [IdxW-1:0]       rd_addr;

    // Per-entry sweep results.
    logic                  entry_keep;
    logic                  entry_hit;

    // Write-back decisions.
    logic                  do_insert;
    logic                  do_refresh;
    logic                  do_remove;
    logic                  refuse;
    logic [CntW-1:0]       cnt_final;

    // Result register.
    logic                  m_valid_reg;
    logic                  member_reg;
    logic                  rvalid_reg;
    logic                  rkind_reg;
    logic [HostW-1:0]      rhost_reg;
    logic [PortW-1:0]      rport_reg;
    logic [CountW-1:0]     count_reg;
    logic                  full_reg;

    // ------------------------------------------------------------------
    // Sequencer: latch in IDLE, sweep all entries, then write back once
    // the result register can take the new result.
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (idx_reg == IdxW'(MaxClients - 1)) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        sweep_en = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready  = 1'b1;
            ST_SWEEP: sweep_en = 1'b1;
            ST_WRITE: commit   = out_free;
            default: ;
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Configuration, clock and the aging limit. The limit is formed once
    // per transaction, so the sweep sees only a subtract and compare.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            now_reg     <= '0;
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            if (accept) begin
                now_reg <= now_reg + TimeW'(s_elapsed_ms);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            limit_reg     <= TimeW'(timeout_reg * MS_PER_SECOND);
            pkt_valid_reg <= s_packet_valid;
            pkt_host_reg  <= s_source_host;
            pkt_port_reg  <= s_source_port;
            pkt_kind_reg  <= pkt_kind_t'(s_packet_kind);
        end
    end

    // ------------------------------------------------------------------
    // Entry memories. The read runs one entry ahead of the sweep: entry 0
    // is read while idle, entry i+1 while entry i is examined.
    // ------------------------------------------------------------------
    assign rd_addr = sweep_en ? idx_reg + IdxW'(1) : '0;

    always_ff @(posedge aclk) begin
        host_rd  <= host_mem[rd_addr];
        stamp_rd <= stamp_mem[rd_addr];
        if (do_insert) begin
            host_mem[free_slot_reg] <= pkt_host_reg;
        end
        if (do_insert) begin
            stamp_mem[free_slot_reg] <= now_reg;
        end else if (do_refresh) begin
            stamp_mem[slot_reg] <= now_reg;
        end
    end

    // ------------------------------------------------------------------
    // Shared age compare and lookup for the entry under the sweep index.
    // An entry that ages out this tick is free and cannot match.
    // ------------------------------------------------------------------
    assign entry_keep = valid_reg[idx_reg] && !((now_reg - stamp_rd) > limit_reg);
    assign entry_hit  = entry_keep && (host_rd == pkt_host_reg);

    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            cnt_reg        <= '0;
        end else if (sweep_en) begin
            idx_reg <= idx_reg + IdxW'(1);
            cnt_reg <= cnt_reg + CntW'(entry_keep);
            if (entry_hit && !found_reg) begin
                found_reg <= 1'b1;
                slot_reg  <= idx_reg;
            end
            if (!entry_keep && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= idx_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Packet handling at write-back.
    // ------------------------------------------------------------------
    assign do_insert  = commit && pkt_valid_reg && !found_reg &&
                        (pkt_kind_reg == KIND_CONNECT) && free_found_reg;
    assign refuse     = pkt_valid_reg && !found_reg &&
                        (pkt_kind_reg == KIND_CONNECT) && !free_found_reg;
    assign do_refresh = commit && pkt_valid_reg && found_reg &&
                        (pkt_kind_reg == KIND_ALIVE);
    assign do_remove  = commit && pkt_valid_reg && found_reg &&
                        (pkt_kind_reg == KIND_DISCONNECT);

    always_comb begin
        cnt_final = cnt_reg;
        if (do_insert) begin
            cnt_final = cnt_reg + CntW'(1);
        end else if (do_remove) begin
            cnt_final = cnt_reg - CntW'(1);
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (sweep_en) begin
            valid_next[idx_reg] = entry_keep;
        end
        if (do_insert) begin
            valid_next[free_slot_reg] = 1'b1;
        end
        if (do_remove) begin
            valid_next[slot_reg] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register. A result waits here until the downstream side takes
    // it, while the next transaction can already be accepted and swept.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            member_reg <= pkt_valid_reg &&
                          ((found_reg && (pkt_kind_reg != KIND_DISCONNECT)) ||
                           (!found_reg && (pkt_kind_reg == KIND_CONNECT) &&
                            free_found_reg));
            rvalid_reg <= do_insert || do_refresh;
            rkind_reg  <= do_refresh ? ACK_ALIVE : ACK_CONNECT;
            rhost_reg  <= (do_insert || do_refresh) ? pkt_host_reg : '0;
            rport_reg  <= (do_insert || do_refresh) ? pkt_port_reg : '0;
            count_reg  <= CountW'(cnt_final);
            full_reg   <= refuse;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_is_member    = member_reg;
    assign m_reply_valid  = rvalid_reg;
    assign m_reply_kind   = rkind_reg;
    assign m_reply_host   = rhost_reg;
    assign m_reply_port   = rport_reg;
    assign m_client_count = count_reg;
    assign m_table_full   = full_reg;

`ifndef SYNTHESIS
    // The reported count matches the valid bits left by the write-back.
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> (m_client_count == CountW'($countones(valid_reg))))
        else $error("client count disagrees with valid bits");

    // A reply is only sent to a host that is a member after handling.
    a_reply_member: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_reply_valid) |-> m_is_member)
        else $error("reply to a non-member");

    // A refused connect only happens with every entry in use.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_table_full) |-> (m_client_count == CountW'(MaxClients)))
        else $error("connect refused with free entries");

    // At most one of insert, refresh and remove happens in a write-back.
    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> ($countones({do_insert, do_refresh, do_remove}) <= 1))
        else $error("more than one table action in one write-back");

    // The sweep hands over to write-back exactly after the last entry.
    a_sweep_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && $past(state_reg) == ST_SWEEP) |->
            ($past(idx_reg) == IdxW'(MaxClients - 1)))
        else $error("sweep ended early");
`endif

endmodule
